### rtl/ebd_pkg.sv
// Shared constants, codes and beat types for the balanced two-wheel move controller.
`default_nettype none

package ebd_pkg;

  // Default datapath widths
  localparam int unsigned DUTY_BITS_DEF  = 10;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Field widths of the stream beats
  localparam int unsigned ROT_W   = 16;
  localparam int unsigned SPEED_W = 10;
  localparam int unsigned OUTD_W  = 10;
  localparam int unsigned TICKS_W = 10;
  localparam int unsigned THR_W   = 8;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 24;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_MS = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 1'd1;

  localparam logic [TICKS_W-1:0] WINDOW_MS_RST = 10'd100;
  localparam logic [THR_W-1:0]   THRESHOLD_RST = 8'd2;

  // Move phase codes; the unused code behaves as idle
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_DRIVE  = 2'd1;
  localparam logic [1:0] PH_FINISH = 2'd2;

  typedef struct packed {
    logic [THR_W-1:0]   threshold;
    logic [TICKS_W-1:0] window_ms;
  } cfg_t;

  typedef struct packed {
    logic               ms_tick;
    logic               right_edge;
    logic               left_edge;
    logic               right_reverse;
    logic               left_reverse;
    logic [SPEED_W-1:0] speed;
    logic [ROT_W-1:0]   right_rotations;
    logic [ROT_W-1:0]   left_rotations;
    logic               start_req;
  } item_t;

  typedef struct packed {
    logic              done_res;
    logic              busy_res;
    logic              right_dir_out;
    logic              left_dir_out;
    logic [OUTD_W-1:0] right_duty;
    logic [OUTD_W-1:0] left_duty;
  } result_t;

endpackage

`default_nettype wire

### rtl/ebd_core.sv
// Move state registers and the single-pass update for one input beat.
`default_nettype none

module ebd_core #(
  parameter int unsigned DUTY_BITS  = ebd_pkg::DUTY_BITS_DEF,
  parameter int unsigned COUNT_BITS = ebd_pkg::COUNT_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire ebd_pkg::item_t  item_i,
  input  wire ebd_pkg::cfg_t   cfg_i,
  output ebd_pkg::result_t     res_o
);

  localparam int unsigned PW = COUNT_BITS + 1;
  localparam logic [PW-1:0] PROG_MAX = {PW{1'b1}};
  localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};
  localparam logic [ebd_pkg::TICKS_W-1:0] TICKS_MAX = {ebd_pkg::TICKS_W{1'b1}};

  logic [1:0]                    phase_q, phase_d;
  logic [PW-1:0]                 lprog_q, lprog_d, rprog_q, rprog_d;
  logic [COUNT_BITS-1:0]         lgoal_q, lgoal_d, rgoal_q, rgoal_d;
  logic [DUTY_BITS-1:0]          base_q, base_d, trim_q, trim_d;
  logic [ebd_pkg::TICKS_W-1:0]   ticks_q, ticks_d;
  logic [PW-1:0]                 lbase_q, lbase_d, rbase_q, rbase_d;
  logic                          ldir_q, ldir_d, rdir_q, rdir_d;

  logic                          active;
  logic [PW-1:0]                 lprog_inc, rprog_inc;
  logic [ebd_pkg::TICKS_W-1:0]   ticks_inc;
  logic                          window_end;
  logic [PW-1:0]                 dl, dr;
  logic                          raise, lower;
  logic [DUTY_BITS-1:0]          trim_up;
  logic                          done;
  logic [DUTY_BITS-1:0]          ld, rd;

  assign active = (phase_q == ebd_pkg::PH_DRIVE) || (phase_q == ebd_pkg::PH_FINISH);

  // Saturating edge counts and window tick count
  assign lprog_inc = (item_i.left_edge && lprog_q != PROG_MAX) ? lprog_q + 1'b1 : lprog_q;
  assign rprog_inc = (item_i.right_edge && rprog_q != PROG_MAX) ? rprog_q + 1'b1 : rprog_q;
  assign ticks_inc = (ticks_q == TICKS_MAX) ? ticks_q : ticks_q + 1'b1;
  assign window_end = !(ticks_inc < cfg_i.window_ms);

  // Edges gained by each wheel since the window started
  assign dl = (lprog_inc >= lbase_q) ? lprog_inc - lbase_q : '0;
  assign dr = (rprog_inc >= rbase_q) ? rprog_inc - rbase_q : '0;
  assign raise = {1'b0, dl} >= ({1'b0, dr} + (PW+1)'(cfg_i.threshold));
  assign trim_up = (raise && trim_q != DUTY_MAX) ? trim_q + 1'b1 : trim_q;
  assign lower = ({1'b0, dr} >= ({1'b0, dl} + (PW+1)'(cfg_i.threshold))) && (trim_up != '0);

  // Next state for the current beat
  always_comb begin
    phase_d = phase_q;
    lprog_d = lprog_q;
    rprog_d = rprog_q;
    lgoal_d = lgoal_q;
    rgoal_d = rgoal_q;
    base_d  = base_q;
    trim_d  = trim_q;
    ticks_d = ticks_q;
    lbase_d = lbase_q;
    rbase_d = rbase_q;
    ldir_d  = ldir_q;
    rdir_d  = rdir_q;
    done    = 1'b0;
    if (!active) begin
      phase_d = ebd_pkg::PH_IDLE;
      if (item_i.start_req) begin
        lgoal_d = COUNT_BITS'(item_i.left_rotations);
        rgoal_d = COUNT_BITS'(item_i.right_rotations);
        base_d  = DUTY_BITS'(item_i.speed);
        trim_d  = DUTY_BITS'(item_i.speed);
        ldir_d  = item_i.left_reverse;
        rdir_d  = item_i.right_reverse;
        lprog_d = '0;
        rprog_d = '0;
        ticks_d = '0;
        lbase_d = '0;
        rbase_d = '0;
        phase_d = ebd_pkg::PH_DRIVE;
      end
    end else begin
      lprog_d = lprog_inc;
      rprog_d = rprog_inc;
      if (phase_q == ebd_pkg::PH_DRIVE) begin
        if (item_i.ms_tick) begin
          if (window_end) begin
            trim_d  = lower ? trim_up - 1'b1 : trim_up;
            ticks_d = '0;
            lbase_d = lprog_inc;
            rbase_d = rprog_inc;
          end else begin
            ticks_d = ticks_inc;
          end
        end
        if (lprog_inc > PW'(lgoal_q)) begin
          phase_d = ebd_pkg::PH_FINISH;
        end
      end
      if (phase_d == ebd_pkg::PH_FINISH && rprog_inc >= PW'(rgoal_q)) begin
        phase_d = ebd_pkg::PH_IDLE;
        done    = 1'b1;
      end
    end
  end

  // Result drawn from the state after the beat
  always_comb begin
    ld = '0;
    rd = '0;
    if (phase_d == ebd_pkg::PH_DRIVE) begin
      ld = base_d;
      rd = (rprog_d >= PW'(rgoal_d)) ? '0 : trim_d;
    end else if (phase_d == ebd_pkg::PH_FINISH) begin
      rd = trim_d;
    end
  end

  assign res_o.left_duty     = ebd_pkg::OUTD_W'(ld);
  assign res_o.right_duty    = ebd_pkg::OUTD_W'(rd);
  assign res_o.left_dir_out  = ldir_d;
  assign res_o.right_dir_out = rdir_d;
  assign res_o.busy_res      = (phase_d != ebd_pkg::PH_IDLE);
  assign res_o.done_res      = done;

  // State registers advance only when a beat is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ebd_pkg::PH_IDLE;
      lprog_q <= '0;
      rprog_q <= '0;
      lgoal_q <= '0;
      rgoal_q <= '0;
      base_q  <= '0;
      trim_q  <= '0;
      ticks_q <= '0;
      lbase_q <= '0;
      rbase_q <= '0;
      ldir_q  <= 1'b0;
      rdir_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      lprog_q <= lprog_d;
      rprog_q <= rprog_d;
      lgoal_q <= lgoal_d;
      rgoal_q <= rgoal_d;
      base_q  <= base_d;
      trim_q  <= trim_d;
      ticks_q <= ticks_d;
      lbase_q <= lbase_d;
      rbase_q <= rbase_d;
      ldir_q  <= ldir_d;
      rdir_q  <= rdir_d;
    end
  end

endmodule

`default_nettype wire

### rtl/encoder_balanced_drive_move.sv
// Top level: input beat register, configuration registers and result register.
//
//   Channel   Direction  Beat content
//   s_axis    in         one sample: start command, targets, speed, edges, ms tick
//   m_axis    out        duties, directions, busy and done for that sample
//   cfg       in         register write: 0 window_ms, 1 imbalance_threshold
//
// Each beat is held in the input register and is folded into the move state as its
// result is registered, so the result is offered from the result register; one
// beat per cycle is sustained while m_axis is not stalled.
// The rate is set by the single-pass update of the move state registers.
// Reset returns the move to idle with all counts zero and the registers at defaults.
// A stall on m_axis holds the result register and then the input register.
`default_nettype none

module encoder_balanced_drive_move #(
  parameter int unsigned DUTY_BITS  = ebd_pkg::DUTY_BITS_DEF,
  parameter int unsigned COUNT_BITS = ebd_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // start_req, left_rotations, right_rotations, speed, left_reverse,
  // right_reverse, left_edge, right_edge, ms_tick (from bit 0 up)
  input  wire logic [ebd_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // left_duty, right_duty, left_dir_out, right_dir_out, busy_res, done_res
  // (from bit 0 up)
  output logic [ebd_pkg::OUT_TDATA_W-1:0]          m_axis_tdata_o,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [ebd_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  wire logic [ebd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  ebd_pkg::cfg_t    cfg_q;
  ebd_pkg::item_t   item_q;
  logic             in_valid_q;
  ebd_pkg::result_t res_d, res_q;
  logic             out_valid_q;
  logic             advance;

  // The update stage moves when the result register is free or being drained
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_ms <= ebd_pkg::WINDOW_MS_RST;
      cfg_q.threshold <= ebd_pkg::THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ebd_pkg::CFG_WINDOW_MS: cfg_q.window_ms <= ebd_pkg::TICKS_W'(cfg_wdata_i);
        ebd_pkg::CFG_THRESHOLD: cfg_q.threshold <= ebd_pkg::THR_W'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Input beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q <= ebd_pkg::item_t'(s_axis_tdata_i);
    end
  end

  // Move state and update logic
  ebd_core #(
    .DUTY_BITS  (DUTY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_valid_q && advance),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = ebd_pkg::OUT_TDATA_W'(res_q);

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the balanced two-wheel move controller.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned REPORT_MAX  = 10;

  logic                            clk_i;
  logic                            rst_ni = 1'b0;
  ebd_pkg::item_t                  s_tdata = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_axis_tready_o;
  logic [ebd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                            m_axis_tvalid_o;
  logic                            m_tready = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [ebd_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [ebd_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Handshake shaping, set by the tests.
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  logic        sink_hold = 1'b0;

  int unsigned      fail_count = 0;
  ebd_pkg::result_t motor_out_q[$];

  // Predicted controller state and registers.
  logic [1:0]  mv_phase;
  logic [16:0] left_cnt, right_cnt;
  logic [15:0] left_goal, right_goal;
  logic [9:0]  base_duty, right_trim;
  logic [9:0]  win_ticks;
  logic [16:0] win_left_base, win_right_base;
  logic        left_dir, right_dir;
  logic [9:0]  win_len;
  logic [7:0]  thr;

  encoder_balanced_drive_move dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Advances the predicted move state by one sample and returns the outputs it shows.
  function automatic ebd_pkg::result_t predict_motor_outputs(ebd_pkg::item_t it);
    ebd_pkg::result_t res;
    int unsigned      dl, dr;
    res = '0;
    if (mv_phase != ebd_pkg::PH_DRIVE && mv_phase != ebd_pkg::PH_FINISH) begin
      mv_phase = ebd_pkg::PH_IDLE;
      if (it.start_req) begin
        left_goal      = it.left_rotations;
        right_goal     = it.right_rotations;
        base_duty      = it.speed;
        right_trim     = it.speed;
        left_dir       = it.left_reverse;
        right_dir      = it.right_reverse;
        left_cnt       = '0;
        right_cnt      = '0;
        win_ticks      = '0;
        win_left_base  = '0;
        win_right_base = '0;
        mv_phase       = ebd_pkg::PH_DRIVE;
      end
    end else begin
      if (it.left_edge && left_cnt != '1) left_cnt = left_cnt + 17'd1;
      if (it.right_edge && right_cnt != '1) right_cnt = right_cnt + 17'd1;
      if (mv_phase == ebd_pkg::PH_DRIVE) begin
        // A window closes on the tick that brings it to its length; zero acts as one.
        if (it.ms_tick) begin
          if (win_ticks != '1) win_ticks = win_ticks + 10'd1;
          if (win_ticks >= win_len) begin
            dl = (left_cnt >= win_left_base) ? 32'(left_cnt - win_left_base) : 0;
            dr = (right_cnt >= win_right_base) ? 32'(right_cnt - win_right_base) : 0;
            if (dl >= dr + thr && right_trim != '1) right_trim = right_trim + 10'd1;
            if (dr >= dl + thr && right_trim != '0) right_trim = right_trim - 10'd1;
            win_ticks      = '0;
            win_left_base  = left_cnt;
            win_right_base = right_cnt;
          end
        end
        if (left_cnt > {1'b0, left_goal}) mv_phase = ebd_pkg::PH_FINISH;
      end
      if (mv_phase == ebd_pkg::PH_FINISH && right_cnt >= {1'b0, right_goal}) begin
        mv_phase     = ebd_pkg::PH_IDLE;
        res.done_res = 1'b1;
      end
    end
    if (mv_phase == ebd_pkg::PH_DRIVE) begin
      res.left_duty  = base_duty;
      res.right_duty = (right_cnt >= {1'b0, right_goal}) ? '0 : right_trim;
    end else if (mv_phase == ebd_pkg::PH_FINISH) begin
      res.right_duty = right_trim;
    end
    res.left_dir_out  = left_dir;
    res.right_dir_out = right_dir;
    res.busy_res      = (mv_phase != ebd_pkg::PH_IDLE);
    return res;
  endfunction

  function automatic ebd_pkg::item_t make_item(logic start, logic [15:0] l_rot,
                                               logic [15:0] r_rot, logic [9:0] spd,
                                               logic l_rev, logic r_rev, logic l_edge,
                                               logic r_edge, logic tick);
    ebd_pkg::item_t it;
    it.start_req       = start;
    it.left_rotations  = l_rot;
    it.right_rotations = r_rot;
    it.speed           = spd;
    it.left_reverse    = l_rev;
    it.right_reverse   = r_rev;
    it.left_edge       = l_edge;
    it.right_edge      = r_edge;
    it.ms_tick         = tick;
    return it;
  endfunction

  function automatic ebd_pkg::item_t rand_item();
    return ebd_pkg::item_t'({16'($urandom), $urandom});
  endfunction

  // Offers one beat, with an optional random gap first, and predicts on acceptance.
  task automatic send_beat(input ebd_pkg::item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it;
    do @(posedge clk_i); while (!s_axis_tready_o);
    motor_out_q.push_back(predict_motor_outputs(it));
  endtask

  // Stops offering and waits until every predicted result has been taken.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (motor_out_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_register(input logic [ebd_pkg::CFG_ADDR_W-1:0] idx,
                              input logic [ebd_pkg::CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    if (idx == ebd_pkg::CFG_WINDOW_MS) win_len = val[9:0];
    else thr = val[7:0];
    cfg_we <= 1'b0;
  endtask

  // Runs the current move to completion with both wheels turning.
  task automatic finish_move();
    while (mv_phase != ebd_pkg::PH_IDLE) send_beat(make_item(0, 0, 0, 0, 0, 0, 1, 1, 0));
  endtask

  // Ignored samples while idle, zero targets, start while busy, held directions.
  task automatic test_idle_and_zero_targets();
    send_beat(make_item(0, 16'hFFFF, 16'hFFFF, 10'h3FF, 1, 1, 1, 1, 1));
    send_beat(make_item(1, 0, 0, 10'h3FF, 1, 1, 1, 1, 1));
    send_beat(make_item(1, 16'h00FF, 16'h00FF, 10'h155, 0, 0, 0, 0, 0));
    send_beat(make_item(0, 0, 0, 0, 0, 0, 0, 1, 1));
    send_beat(make_item(0, 0, 0, 0, 0, 0, 1, 0, 0));
    send_beat(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Right duty trim in both directions, its limits, and the degenerate settings.
  task automatic test_trim_limits();
    set_register(ebd_pkg::CFG_WINDOW_MS, 10'd1);
    set_register(ebd_pkg::CFG_THRESHOLD, 10'd1);
    send_beat(make_item(1, 1, 1, 10'h3FF, 0, 1, 0, 0, 0));
    send_beat(make_item(0, 0, 0, 0, 0, 0, 1, 0, 1));
    send_beat(make_item(0, 0, 0, 0, 0, 0, 0, 1, 1));
    finish_move();
    send_beat(make_item(1, 0, 2, 10'h000, 1, 0, 0, 0, 0));
    send_beat(make_item(0, 0, 0, 0, 0, 0, 0, 1, 1));
    finish_move();
    // Threshold zero makes both trims fire; a zero window closes on every tick.
    set_register(ebd_pkg::CFG_WINDOW_MS, 10'd0);
    set_register(ebd_pkg::CFG_THRESHOLD, 10'd0);
    send_beat(make_item(1, 0, 1, 10'h3FF, 1, 1, 0, 0, 0));
    send_beat(make_item(0, 0, 0, 0, 0, 0, 0, 0, 1));
    send_beat(make_item(0, 0, 0, 0, 0, 0, 0, 0, 1));
    finish_move();
    send_beat(make_item(1, 0, 1, 10'h000, 0, 0, 0, 0, 0));
    send_beat(make_item(0, 0, 0, 0, 0, 0, 0, 0, 1));
    finish_move();
  endtask

  // A longer move over many windows, with the right wheel running ahead of the left.
  task automatic test_long_move();
    set_register(ebd_pkg::CFG_WINDOW_MS, 10'd7);
    set_register(ebd_pkg::CFG_THRESHOLD, 10'd3);
    send_beat(make_item(1, 16'd60, 16'd90, 10'd512, 0, 1, 0, 0, 0));
    while (mv_phase != ebd_pkg::PH_IDLE) begin
      send_beat(make_item(0, 0, 0, 0, 0, 0, 1'($urandom), 1'($urandom_range(9) < 7),
                          1'($urandom)));
    end
  endtask

  // Mostly complete moves with random content, plus ignored samples between them.
  task automatic test_random_moves(input int unsigned n_items);
    int unsigned    sent, pl, pr, pt;
    ebd_pkg::item_t it;
    sent = 0;
    while (sent < n_items) begin
      it = rand_item();
      if ($urandom_range(99) < 12) begin
        it.start_req = 1'b0;
        send_beat(it);
      end else begin
        it.start_req = 1'b1;
        it.left_rotations  = 16'($urandom_range($urandom_range(9) == 0 ? 40 : 12));
        it.right_rotations = 16'($urandom_range($urandom_range(9) == 0 ? 40 : 12));
        if ($urandom_range(9) == 0) it.speed = {10{1'($urandom)}};
        send_beat(it);
        sent++;
        pl = $urandom_range(15, 90);
        pr = $urandom_range(15, 90);
        pt = $urandom_range(10, 70);
        while (mv_phase != ebd_pkg::PH_IDLE) begin
          it = rand_item();
          if ($urandom_range(9) != 0) it.start_req = 1'b0;
          it.left_edge  = ($urandom_range(99) < pl);
          it.right_edge = ($urandom_range(99) < pr);
          it.ms_tick    = ($urandom_range(99) < pt);
          send_beat(it);
          sent++;
        end
      end
    end
  endtask

  task automatic test_random_phase(input logic [9:0] win, input logic [7:0] th,
                                   input int unsigned src_pct, input int unsigned sink_pct,
                                   input int unsigned n_items);
    set_register(ebd_pkg::CFG_WINDOW_MS, win);
    set_register(ebd_pkg::CFG_THRESHOLD, ebd_pkg::CFG_DATA_W'(th));
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    test_random_moves(n_items);
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while beats keep coming.
  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    fork
      begin
        sink_hold <= 1'b1;
        repeat (300) @(posedge clk_i);
        sink_hold <= 1'b0;
      end
      test_random_moves(80);
    join
    wait_idle();
  endtask

  // Takes result beats and compares them with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    ebd_pkg::result_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got = ebd_pkg::result_t'(m_axis_tdata_o);
      if (motor_out_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) $display("unexpected result beat %h", got);
      end else begin
        want = motor_out_q.pop_front();
        if (got.left_duty !== want.left_duty || got.right_duty !== want.right_duty ||
            got.left_dir_out !== want.left_dir_out ||
            got.right_dir_out !== want.right_dir_out ||
            got.busy_res !== want.busy_res || got.done_res !== want.done_res) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display({"mismatch: expected ld=%0d rd=%0d dirs=%b%b busy=%b done=%b, ",
                      "got ld=%0d rd=%0d dirs=%b%b busy=%b done=%b"},
                     want.left_duty, want.right_duty, want.left_dir_out,
                     want.right_dir_out, want.busy_res, want.done_res,
                     got.left_duty, got.right_duty, got.left_dir_out,
                     got.right_dir_out, got.busy_res, got.done_res);
        end
      end
    end
    m_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
  end

  // Ends a hung run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : main
    mv_phase       = ebd_pkg::PH_IDLE;
    left_cnt       = '0;
    right_cnt      = '0;
    left_goal      = '0;
    right_goal     = '0;
    base_duty      = '0;
    right_trim     = '0;
    win_ticks      = '0;
    win_left_base  = '0;
    win_right_base = '0;
    left_dir       = 1'b0;
    right_dir      = 1'b0;
    win_len        = ebd_pkg::WINDOW_MS_RST;
    thr            = ebd_pkg::THRESHOLD_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_idle_and_zero_targets();
    test_trim_limits();
    test_long_move();
    test_backpressure();
    test_random_phase(10'd3, 8'd1, 0, 0, 400);
    test_random_phase(10'd1023, 8'd255, 58, 0, 400);
    test_random_phase(10'd0, 8'd0, 0, 58, 400);
    test_random_phase(10'd2, 8'd2, 29, 29, 400);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && motor_out_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
